@@ hdl/aelr_pkg.sv @@
// ----------------------------------------------------------------------------
// aelr_pkg
// Shared types and constants for the accelerated encoder LED ring block.
// ----------------------------------------------------------------------------
package aelr_pkg;

  localparam int RING_LEDS = 16;
  localparam int RING_W    = $clog2(RING_LEDS);
  localparam int PAT_W     = 16;

  localparam logic [15:0] FAST_LIMIT_RST   = 16'd150;
  localparam logic [15:0] MEDIUM_LIMIT_RST = 16'd400;
  localparam logic [15:0] SLOW_LIMIT_RST   = 16'd750;
  localparam logic [6:0]  MAX_SPEED_RST    = 7'd99;
  localparam logic [15:0] PERIOD_BASE_RST  = 16'd1000;
  localparam logic [7:0]  PERIOD_STEP_RST  = 8'd10;
  localparam logic [15:0] SINCE_MAX        = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_EDGE_A = 2'd1,
    OP_EDGE_B = 2'd2,
    OP_BUTTON = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_FAST_LIMIT   = 3'd0,
    REG_MEDIUM_LIMIT = 3'd1,
    REG_SLOW_LIMIT   = 3'd2,
    REG_MAX_SPEED    = 3'd3,
    REG_PERIOD_BASE  = 3'd4,
    REG_PERIOD_STEP  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_UP   = 2'd1,
    ROT_DOWN = 2'd2
  } rot_t;

  typedef struct packed {
    logic [15:0] fast_limit;
    logic [15:0] medium_limit;
    logic [15:0] slow_limit;
    logic [6:0]  max_speed;
    logic [15:0] period_base;
    logic [7:0]  period_step;
  } cfg_t;

  typedef struct packed {
    logic [6:0]        speed;
    rot_t              pending;
    logic              change_seen;
    logic [15:0]       since_change;
    logic              press_seen;
    logic              tick_since_press;
    logic              pressed;
    logic              dir;
    logic [RING_W-1:0] pos;
    logic [15:0]       period_left;
  } state_t;

  // packed so that the pattern sits in the low bits
  typedef struct packed {
    logic             pressed_now;
    logic             dir_now;
    logic [6:0]       speed_now;
    logic             led_write;
    logic [PAT_W-1:0] led_pattern;
  } res_t;

endpackage

@@ hdl/aelr_core.sv @@
// ----------------------------------------------------------------------------
// aelr_core
// Next-state and result logic for one item: tick, encoder edge or button edge.
// ----------------------------------------------------------------------------
module aelr_core
  import aelr_pkg::*;
(
  input  state_t st,
  input  cfg_t   cfg,
  input  op_t    op,
  input  logic   enc_a,
  input  logic   enc_b,
  output state_t st_nxt,
  output res_t   res
);

  logic [14:0]        prod;
  logic signed [17:0] period;
  logic [15:0]        period_m1;
  logic [RING_W-1:0]  pos_up;
  logic [RING_W-1:0]  pos_dn;
  logic [2:0]         mag;
  logic signed [8:0]  sum;
  logic [6:0]         speed_clamped;

  always_comb begin
    prod   = 15'({8'b0, st.speed} * {7'b0, cfg.period_step});
    period = $signed({2'b00, cfg.period_base}) - $signed({3'b000, prod});
    // period floors at 1, so the reload is period - 1 floored at 0
    period_m1 = (period < 18'sd1) ? 16'd0 : 16'(period - 18'sd1);

    pos_up = (st.pos == RING_W'(RING_LEDS - 1)) ? '0 : st.pos + 1'b1;
    pos_dn = (st.pos == '0) ? RING_W'(RING_LEDS - 1) : st.pos - 1'b1;

    mag = 3'd1;
    if (st.change_seen) begin
      if (st.since_change < cfg.fast_limit) begin
        mag = 3'd4;
      end else if (st.since_change < cfg.medium_limit) begin
        mag = 3'd3;
      end else if (st.since_change < cfg.slow_limit) begin
        mag = 3'd2;
      end
    end

    case (st.pending)
      ROT_UP:   sum = $signed({2'b00, st.speed}) + $signed({6'b0, mag});
      ROT_DOWN: sum = $signed({2'b00, st.speed}) - $signed({6'b0, mag});
      default:  sum = $signed({2'b00, st.speed});
    endcase

    if (sum < 9'sd0) begin
      speed_clamped = '0;
    end else if (sum > $signed({2'b00, cfg.max_speed})) begin
      speed_clamped = cfg.max_speed;
    end else begin
      speed_clamped = sum[6:0];
    end

    st_nxt        = st;
    res.led_write = 1'b0;

    case (op) inside
      OP_TICK: begin
        if (st.since_change != SINCE_MAX) begin
          st_nxt.since_change = st.since_change + 16'd1;
        end
        st_nxt.tick_since_press = 1'b1;
        if (st.period_left != '0) begin
          st_nxt.period_left = st.period_left - 16'd1;
        end else if (st.speed != '0) begin
          st_nxt.pos         = st.dir ? pos_dn : pos_up;
          st_nxt.period_left = period_m1;
          res.led_write      = 1'b1;
        end
      end
      OP_EDGE_A, OP_EDGE_B: begin
        if (enc_a != enc_b) begin
          // first half of a detent: latch which line led
          if (st.pending == ROT_NONE) begin
            st_nxt.pending = (op == OP_EDGE_A) ? ROT_UP : ROT_DOWN;
          end
        end else begin
          st_nxt.speed        = speed_clamped;
          st_nxt.change_seen  = 1'b1;
          st_nxt.since_change = '0;
          st_nxt.pending      = ROT_NONE;
        end
      end
      default: begin
        if (!st.press_seen || st.tick_since_press) begin
          st_nxt.pressed = !st.pressed;
          if (!st.pressed) begin
            st_nxt.dir = !st.dir;
          end
        end
        st_nxt.press_seen       = 1'b1;
        st_nxt.tick_since_press = 1'b0;
      end
    endcase

    for (int i = 0; i < PAT_W; i++) begin
      res.led_pattern[i] = (int'(st_nxt.pos) == i);
    end
    res.speed_now   = st_nxt.speed;
    res.dir_now     = st_nxt.dir;
    res.pressed_now = st_nxt.pressed;
  end

endmodule

@@ hdl/accelerated_encoder_led_ring.sv @@
// ----------------------------------------------------------------------------
// accelerated_encoder_led_ring
// Rotary encoder decoder with speed acceleration driving a one-hot LED ring.
// ----------------------------------------------------------------------------
// Input channel (in_*): one item per event. in_tuser carries the event kind
// (tick, edge on line A, edge on line B, button edge); in_tdata carries the
// sampled encoder levels. Every item yields exactly one result item on the
// out_* channel with the LED pattern, a write flag, speed, direction and the
// pressed flag as they stand after the item.
// An item accepted at a clock edge shows on out_tvalid right after it.
// Throughput is one item per cycle while the receiver takes each result;
// the state and output registers both update at the accepting edge.
// If the receiver stalls, the output register holds its item and in_tready
// drops until it is taken; in_tready is high whenever the output register is
// empty or being emptied in the same cycle.
// The cfg_* port writes a register at any edge with cfg_we high; writes to
// unused indexes are dropped. Write only while no item is in flight.
// Reset (rst_n low at a clock edge) restores the register defaults, clears
// speed, direction, pressed state and counters, puts the ring at LED 0 and
// empties the output register.
// ----------------------------------------------------------------------------
module accelerated_encoder_led_ring
  import aelr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] enc_a, [1] enc_b, [7:2] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] led_pattern, [16] led_write, [23:17] speed_now, [24] dir_now,
  // [25] pressed_now, [31:26] zero
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  state_t st_r;
  state_t st_nxt;
  cfg_t   cfg_r;
  res_t   res;
  res_t   res_r;
  logic   out_valid_r;
  logic   accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  aelr_core u_core (
    .st     (st_r),
    .cfg    (cfg_r),
    .op     (op_t'(in_tuser)),
    .enc_a  (in_tdata[0]),
    .enc_b  (in_tdata[1]),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_limit   <= FAST_LIMIT_RST;
      cfg_r.medium_limit <= MEDIUM_LIMIT_RST;
      cfg_r.slow_limit   <= SLOW_LIMIT_RST;
      cfg_r.max_speed    <= MAX_SPEED_RST;
      cfg_r.period_base  <= PERIOD_BASE_RST;
      cfg_r.period_step  <= PERIOD_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_FAST_LIMIT:   cfg_r.fast_limit   <= cfg_wdata;
        REG_MEDIUM_LIMIT: cfg_r.medium_limit <= cfg_wdata;
        REG_SLOW_LIMIT:   cfg_r.slow_limit   <= cfg_wdata;
        REG_MAX_SPEED:    cfg_r.max_speed    <= cfg_wdata[6:0];
        REG_PERIOD_BASE:  cfg_r.period_base  <= cfg_wdata;
        REG_PERIOD_STEP:  cfg_r.period_step  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.speed            <= '0;
      st_r.pending          <= ROT_NONE;
      st_r.change_seen      <= 1'b0;
      st_r.since_change     <= '0;
      st_r.press_seen       <= 1'b0;
      st_r.tick_since_press <= 1'b0;
      st_r.pressed          <= 1'b0;
      st_r.dir              <= 1'b0;
      st_r.pos              <= '0;
      st_r.period_left      <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, res_r};

endmodule

@@ hdl/aelr_checker.sv @@
// ----------------------------------------------------------------------------
// aelr_checker
// Port-level checks on the LED ring block, bound to the top level.
// ----------------------------------------------------------------------------
module aelr_checker
  import aelr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // every accepted item shows up on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item produced no result");

  // no new item while a result is stuck in the output register
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("item accepted over a stalled result");

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tdata[PAT_W-1:0]))
    else $error("LED pattern not one-hot");

endmodule

bind accelerated_encoder_led_ring aelr_checker u_aelr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/accelerated_encoder_led_ring_tb.sv @@
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// accelerated_encoder_led_ring_tb
// Self-checking bench for the encoder LED ring. Items go in on the in_*
// stream. A behavioral copy of the block predicts the result of each item,
// and every item that comes out on out_* is compared field by field with the
// oldest prediction. Directed sequences come first, then register extremes,
// a run of ticks between detents with every limit at its ceiling, a long
// receiver hold, and random traffic under several register settings. Both
// sides insert random gaps.
// ----------------------------------------------------------------------------
module accelerated_encoder_led_ring_tb;
  import aelr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 96;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 125;
  localparam int SATURATE_TICKS = 40;
  localparam int PRINT_CAP      = 40;

  // indexes with no register behind them
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = OP_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_addr   = '0;
  logic [15:0] cfg_wdata  = '0;

  accelerated_encoder_led_ring dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // shadow of the block: registers and state
  cfg_t              mdl_cfg;
  logic [6:0]        mdl_speed;
  rot_t              mdl_pending;
  logic              mdl_change_seen;
  logic [15:0]       mdl_since;
  logic              mdl_press_seen;
  logic              mdl_tick_seen;
  logic              mdl_pressed;
  logic              mdl_dir;
  logic [RING_W-1:0] mdl_pos;
  logic [15:0]       mdl_countdown;

  res_t led_expect_q[$];
  int   mismatches  = 0;
  int   idle_cycles = 0;
  bit   tx_steady   = 1'b0;
  bit   rx_steady   = 1'b0;
  bit   hold_req    = 1'b0;

  initial forever #1 clk = ~clk;

  function automatic void ring_model_reset();
    mdl_cfg.fast_limit   = FAST_LIMIT_RST;
    mdl_cfg.medium_limit = MEDIUM_LIMIT_RST;
    mdl_cfg.slow_limit   = SLOW_LIMIT_RST;
    mdl_cfg.max_speed    = MAX_SPEED_RST;
    mdl_cfg.period_base  = PERIOD_BASE_RST;
    mdl_cfg.period_step  = PERIOD_STEP_RST;
    mdl_speed       = '0;
    mdl_pending     = ROT_NONE;
    mdl_change_seen = 1'b0;
    mdl_since       = '0;
    mdl_press_seen  = 1'b0;
    mdl_tick_seen   = 1'b0;
    mdl_pressed     = 1'b0;
    mdl_dir         = 1'b0;
    mdl_pos         = '0;
    mdl_countdown   = '0;
  endfunction

  function automatic res_t predict_led_ring(op_t op, logic a, logic b);
    res_t r;
    int   delta;
    int   sp;
    int   per;
    logic wrote;
    wrote = 1'b0;
    case (op)
      OP_TICK: begin
        if (mdl_since != SINCE_MAX) mdl_since = mdl_since + 16'd1;
        mdl_tick_seen = 1'b1;
        if (mdl_countdown != 0) begin
          mdl_countdown = mdl_countdown - 16'd1;
        end else if (mdl_speed != 0) begin
          if (!mdl_dir) mdl_pos = (mdl_pos == RING_LEDS - 1) ? '0 : mdl_pos + 1'b1;
          else mdl_pos = (mdl_pos == 0) ? RING_W'(RING_LEDS - 1) : mdl_pos - 1'b1;
          wrote = 1'b1;
          per = int'(mdl_cfg.period_base) - int'(mdl_speed) * int'(mdl_cfg.period_step);
          if (per < 1) per = 1;
          mdl_countdown = 16'(per - 1);
        end
      end
      OP_EDGE_A, OP_EDGE_B: begin
        if (a != b) begin
          // only the first unequal edge decides the direction
          if (mdl_pending == ROT_NONE) mdl_pending = (op == OP_EDGE_A) ? ROT_UP : ROT_DOWN;
        end else begin
          delta = (mdl_pending == ROT_UP) ? 1 : (mdl_pending == ROT_DOWN) ? -1 : 0;
          if (mdl_change_seen) begin
            if (mdl_since < mdl_cfg.fast_limit) delta = delta * 4;
            else if (mdl_since < mdl_cfg.medium_limit) delta = delta * 3;
            else if (mdl_since < mdl_cfg.slow_limit) delta = delta * 2;
          end
          mdl_change_seen = 1'b1;
          mdl_since = '0;
          sp = int'(mdl_speed) + delta;
          if (sp < 0) sp = 0;
          if (sp > int'(mdl_cfg.max_speed)) sp = int'(mdl_cfg.max_speed);
          mdl_speed = 7'(sp);
          mdl_pending = ROT_NONE;
        end
      end
      default: begin
        if (!mdl_press_seen || mdl_tick_seen) begin
          mdl_pressed = !mdl_pressed;
          if (mdl_pressed) mdl_dir = !mdl_dir;
        end
        mdl_press_seen = 1'b1;
        mdl_tick_seen = 1'b0;
      end
    endcase
    r.led_pattern = '0;
    r.led_pattern[mdl_pos] = 1'b1;
    r.led_write = wrote;
    r.speed_now = mdl_speed;
    r.dir_now = mdl_dir;
    r.pressed_now = mdl_pressed;
    return r;
  endfunction

  // mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return 16'hFFFF;
      1: return 16'h0000;
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // always entered and left right after a rising edge
  task automatic send_item(op_t op, logic a, logic b);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, b, a};
    do @(posedge clk); while (!in_tready);
    led_expect_q.push_back(predict_led_ring(op, a, b));
    if (!tx_steady && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (led_expect_q.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FAST_LIMIT:   mdl_cfg.fast_limit = value;
      REG_MEDIUM_LIMIT: mdl_cfg.medium_limit = value;
      REG_SLOW_LIMIT:   mdl_cfg.slow_limit = value;
      REG_MAX_SPEED:    mdl_cfg.max_speed = value[6:0];
      REG_PERIOD_BASE:  mdl_cfg.period_base = value;
      REG_PERIOD_STEP:  mdl_cfg.period_step = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one detent: unequal edge on the leading line, then equal edge on the other
  task automatic send_detent(bit down);
    logic lvl;
    lvl = $urandom_range(0, 1);
    if (!down) begin
      send_item(OP_EDGE_A, lvl, !lvl);
      lvl = $urandom_range(0, 1);
      send_item(OP_EDGE_B, lvl, lvl);
    end else begin
      send_item(OP_EDGE_B, lvl, !lvl);
      lvl = $urandom_range(0, 1);
      send_item(OP_EDGE_A, lvl, lvl);
    end
  endtask

  task automatic apply_random_settings();
    write_reg(REG_FAST_LIMIT, pick_limit());
    write_reg(REG_MEDIUM_LIMIT, pick_limit());
    write_reg(REG_SLOW_LIMIT, pick_limit());
    write_reg(REG_MAX_SPEED, ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom));
    write_reg(REG_PERIOD_BASE,
              ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 48)));
    write_reg(REG_PERIOD_STEP, {8'($urandom),
              ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3))});
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
  endtask

  task automatic test_directed_sequences();
    send_item(OP_EDGE_A, 1'b1, 1'b0);  // line A leads: up
    send_item(OP_EDGE_B, 1'b1, 1'b1);  // first change since reset, unscaled
    send_item(OP_EDGE_A, 1'b0, 1'b0);  // nothing pending, zero step
    send_item(OP_EDGE_A, 1'b0, 1'b1);
    send_item(OP_EDGE_B, 1'b1, 1'b0);  // direction already latched
    send_item(OP_EDGE_B, 1'b0, 1'b0);  // fast: x4
    send_item(OP_BUTTON, 1'b1, 1'b1);  // first press toggles, ring reverses
    send_item(OP_BUTTON, 1'b0, 1'b0);  // no tick in between: ignored
    send_item(OP_TICK, 1'b1, 1'b0);    // ring starts downward, wraps to top
    send_item(OP_TICK, 1'b0, 1'b1);
    send_item(OP_EDGE_B, 1'b1, 1'b0);  // line B leads: down
    send_item(OP_EDGE_A, 1'b1, 1'b1);
    send_item(OP_EDGE_B, 1'b0, 1'b1);
    send_item(OP_EDGE_A, 1'b0, 1'b0);  // floor at zero
    send_item(OP_BUTTON, 1'b1, 1'b0);  // release: no reversal
    send_item(OP_TICK, 1'b1, 1'b1);
    send_item(OP_BUTTON, 1'b0, 1'b1);  // press: back to upward
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_MAX_SPEED, 16'd1);
    write_reg(REG_PERIOD_BASE, 16'd1);
    write_reg(REG_PERIOD_STEP, 16'd255);
    send_detent(1'b0);                 // clamps at the ceiling of 1
    repeat (18) send_item(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1));
    send_detent(1'b1);
    wait_drained();
    write_reg(REG_MAX_SPEED, 16'd0);   // speed pinned at zero
    write_reg(REG_SPARE_6, 16'hFFFF);
    write_reg(REG_SPARE_7, 16'h0000);
    send_detent(1'b0);
    send_item(OP_TICK, 1'b0, 1'b0);
    wait_drained();
    write_reg(REG_MAX_SPEED, 16'hFFFF);
    write_reg(REG_PERIOD_BASE, 16'hFFFF);
    write_reg(REG_PERIOD_STEP, 16'hFF00);
    write_reg(REG_FAST_LIMIT, 16'hFFFF);
    write_reg(REG_MEDIUM_LIMIT, 16'hFFFF);
    write_reg(REG_SLOW_LIMIT, 16'hFFFF);
    send_detent(1'b0);
    send_item(OP_TICK, 1'b1, 1'b1);
    wait_drained();
    write_reg(REG_FAST_LIMIT, 16'h0000);
    write_reg(REG_MEDIUM_LIMIT, 16'h0000);
    write_reg(REG_SLOW_LIMIT, 16'h0000);
    write_reg(REG_PERIOD_STEP, 16'h00FF);
    send_detent(1'b0);                 // no scaling at any elapsed time
    send_item(OP_TICK, 1'b0, 1'b1);
    send_detent(1'b1);
    wait_drained();
  endtask

  // steady run of ticks between detents, every limit at its ceiling
  task automatic test_since_saturation();
    write_reg(REG_FAST_LIMIT, 16'hFFFF);
    write_reg(REG_MEDIUM_LIMIT, 16'hFFFF);
    write_reg(REG_SLOW_LIMIT, 16'hFFFF);
    write_reg(REG_PERIOD_BASE, 16'd3);
    write_reg(REG_PERIOD_STEP, 16'd1);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_detent(1'b0);
    repeat (SATURATE_TICKS) send_item(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1));
    send_detent(1'b0);
    send_detent(1'b1);
    wait_drained();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    tx_steady = 1'b1;
    hold_req  = 1'b1;
    repeat (20) send_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                          $urandom_range(0, 1));
    wait_drained();
    tx_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int sent;
    int kind;
    int n;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_random_settings();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          send_detent($urandom_range(0, 1));
          sent += 2;
        end else if (kind < 80) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
          repeat (n) send_item(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1));
          sent += n;
        end else if (kind < 88) begin
          send_item(OP_BUTTON, $urandom_range(0, 1), $urandom_range(0, 1));
          sent++;
        end else begin
          send_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 1), $urandom_range(0, 1));
          sent++;
        end
      end
      wait_drained();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[25:0]);
      if (led_expect_q.size() == 0) begin
        report_mismatch("unexpected item", out_tdata, '0);
      end else begin
        want = led_expect_q.pop_front();
        if (got.led_pattern !== want.led_pattern)
          report_mismatch("led_pattern", got.led_pattern, want.led_pattern);
        if (got.led_write !== want.led_write)
          report_mismatch("led_write", got.led_write, want.led_write);
        if (got.speed_now !== want.speed_now)
          report_mismatch("speed_now", got.speed_now, want.speed_now);
        if (got.dir_now !== want.dir_now)
          report_mismatch("dir_now", got.dir_now, want.dir_now);
        if (got.pressed_now !== want.pressed_now)
          report_mismatch("pressed_now", got.pressed_now, want.pressed_now);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ring_model_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_sequences();
    test_register_extremes();
    test_since_saturation();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk);
    if (led_expect_q.size() != 0)
      report_mismatch("missing items", led_expect_q.size(), '0);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
